/* rtl/mlpsc_pkg.sv */
// shared constants, types and the sigmoid function of the perceptron classifier
package mlpsc_pkg;

  // default size of the hidden layer
  localparam int unsigned HIDDEN_UNITS_DEF = 8;

  // transaction codes
  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_e;

  // third feature register reset value, giving a third feature of 1.0 in Q2.14
  localparam logic [15:0] THIRD_RESET = 16'd19005;

  // feature scaling: rounded quotients, saturated at 2.0 in Q2.14
  localparam logic [15:0] FEAT_SAT  = 16'd32768;
  localparam logic [32:0] RND0      = 33'd100000;
  localparam logic [32:0] RND1      = 33'd40000;
  localparam logic [32:0] RND2      = 33'd14;

  // divide by reciprocal multiplication, exact over each dividend range
  // 200000 = 64 * 3125, 80000 = 128 * 625; reciprocals are ceil(2^RSH / divisor)
  localparam int unsigned PRE0   = 6;
  localparam int unsigned PRE1   = 7;
  localparam logic [27:0] RECIP0 = 28'd175921861;
  localparam logic [26:0] RECIP1 = 27'd109951163;
  localparam logic [21:0] RECIP2 = 22'd2314099;
  localparam int unsigned RSH0   = 39;
  localparam int unsigned RSH1   = 36;
  localparam int unsigned RSH2   = 26;

  // bias operands: 1.0 in the feature and activation formats
  localparam logic [16:0] ONE_Q14 = 17'd16384;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // rounding of the sums down to Q.16
  localparam int unsigned HID_SHIFT = 10;
  localparam int unsigned OUT_SHIFT = 12;

  // piecewise linear sigmoid breakpoints and offsets
  localparam logic [18:0] SIG_SAT   = 19'd327680;
  localparam logic [18:0] SIG_KNEE2 = 19'd155648;
  localparam logic [18:0] SIG_KNEE1 = 19'd65536;
  localparam logic [16:0] SIG_ONE   = 17'd65536;
  localparam logic [16:0] SIG_OFF2  = 17'd55296;
  localparam logic [16:0] SIG_OFF1  = 17'd40960;
  localparam logic [16:0] SIG_OFF0  = 17'd32768;

  // class threshold, 0.5 in Q0.16
  localparam logic [15:0] SCORE_HALF = 16'd32768;

  // sigmoid on a rounded magnitude in Q.16, mirrored for negative sums
  function automatic logic [15:0] plan_sig(input logic [18:0] a, input logic neg);
    logic [16:0] y;
    logic [16:0] r;
    priority if (a >= SIG_SAT) begin
      y = SIG_ONE;
    end else if (a >= SIG_KNEE2) begin
      y = 17'(a >> 5) + SIG_OFF2;
    end else if (a >= SIG_KNEE1) begin
      y = 17'(a >> 3) + SIG_OFF1;
    end else begin
      y = 17'(a >> 2) + SIG_OFF0;
    end
    r = neg ? (SIG_ONE - y) : y;
    return r[16] ? 16'hFFFF : r[15:0];
  endfunction

endpackage

/* rtl/mlp_sigmoid_binary_classifier_unit.sv */
// two layer sigmoid perceptron classifier with weight store and reciprocal feature scaling
// latency: a load transaction is written in the cycle it is accepted, no result
// a classify transaction gives its result after feature scaling and both network layers
// throughput: one load per cycle while idle; a classify holds the input until done, one
//   multiply-accumulate per weight plus scaling and drain; a pending result stalls the next
// reset: control state cleared, third feature set to 19005, weight store undefined until loaded
module mlp_sigmoid_binary_classifier_unit #(
  parameter int unsigned HIDDEN_UNITS = mlpsc_pkg::HIDDEN_UNITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [5:0]         weight_index_i,
  input  logic signed [15:0] weight_value_i,
  input  logic [31:0]        first_level_i,
  input  logic [31:0]        second_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               class_out_o,
  output logic [15:0]        score_o
);
  import mlpsc_pkg::*;

  localparam int unsigned STORE_DEPTH = 5 * HIDDEN_UNITS + 1;
  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned UW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int unsigned ACC_W = 33 + $clog2(HIDDEN_UNITS + 1);

  localparam logic [UW-1:0] LAST_UNIT     = UW'(HIDDEN_UNITS - 1);
  localparam logic [AW-1:0] HID_W1_BASE   = AW'(HIDDEN_UNITS);
  localparam logic [AW-1:0] HID_W2_BASE   = AW'(2 * HIDDEN_UNITS);
  localparam logic [AW-1:0] HID_BIAS_BASE = AW'(3 * HIDDEN_UNITS);
  localparam logic [AW-1:0] OUT_W_BASE    = AW'(4 * HIDDEN_UNITS);
  localparam logic [AW-1:0] OUT_BIAS_ADDR = AW'(5 * HIDDEN_UNITS);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_HID   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  // element selects within one neuron
  localparam logic [1:0] SEL_BIAS = 2'd0;
  localparam logic [1:0] SEL_X0   = 2'd1;
  localparam logic [1:0] SEL_X1   = 2'd2;
  localparam logic [1:0] SEL_X2   = 2'd3;

  // tag that travels with each memory read down the datapath
  typedef struct packed {
    logic          valid;
    logic          first;
    logic          last;
    logic          layer;
    logic [1:0]    sel;
    logic [UW-1:0] unit;
  } tag_t;

  logic [2:0]    state_q, state_d;
  logic [UW-1:0] unit_q, unit_d;
  logic [1:0]    elem_q, elem_d;
  logic [15:0]   third_q;

  logic          in_acc;
  logic          load_we;
  logic          classify_start;
  logic [AW-1:0] wr_addr;

  // feature scaling registers
  logic [32:0] dvd      [3];
  logic [26:0] n0_q;
  logic [25:0] n1_q;
  logic [20:0] n2_q;
  logic [54:0] scl_prod [3];
  logic [16:0] quo      [3];
  logic [15:0] feat_d   [3];
  logic [15:0] feat_q   [3];

  // memories
  logic signed [15:0] wmem [STORE_DEPTH];
  logic [15:0]        hmem [HIDDEN_UNITS];
  logic signed [15:0] w_rd_q;
  logic [15:0]        h_rd_q;

  // issue stage
  tag_t          iss;
  logic [AW-1:0] iss_addr;
  logic [AW-1:0] iss_base;

  // datapath stages
  tag_t                    s1_q, s2_q, s3_q, s4_q;
  tag_t                    s3_d;
  logic [16:0]             opnd;
  logic signed [33:0]      prod_d, prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]        acc_u, mag, mag_sh;
  logic                    acc_neg;
  logic [18:0]             a_d, a_q;
  logic                    neg_q;
  logic [15:0]             sig_y;
  logic                    pipe_empty;

  // output register
  logic        out_valid_q;
  logic        class_q;
  logic [15:0] score_q;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_acc         = in_valid_i && in_ready_o;
  assign load_we        = in_acc && (op_i == OP_LOAD) && (32'(weight_index_i) < 32'(STORE_DEPTH));
  assign classify_start = in_acc && (op_i == OP_CLASSIFY);
  assign wr_addr        = AW'(weight_index_i);
  assign pipe_empty     = !s1_q.valid && !s2_q.valid && !s3_q.valid && !s4_q.valid;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      third_q <= THIRD_RESET;
    end else if (cfg_we_i) begin
      third_q <= cfg_wdata_i;
    end
  end

  // rounded dividends
  always_comb begin
    dvd[0] = 33'(first_level_i) + RND0;
    dvd[1] = 33'(second_level_i) + RND1;
    dvd[2] = 33'({third_q, 4'b0}) + 33'({third_q, 3'b0}) + 33'(third_q) + RND2;
  end

  // reciprocal multiplication, quotient saturated at 2.0
  always_comb begin
    scl_prod[0] = 55'(n0_q) * 55'(RECIP0);
    scl_prod[1] = 55'(n1_q) * 55'(RECIP1);
    scl_prod[2] = 55'(n2_q) * 55'(RECIP2);
    quo[0]      = 17'(scl_prod[0] >> RSH0);
    quo[1]      = 17'(scl_prod[1] >> RSH1);
    quo[2]      = 17'(scl_prod[2] >> RSH2);
    for (int k = 0; k < 3; k++) begin
      feat_d[k] = (quo[k] >= 17'(FEAT_SAT)) ? FEAT_SAT : quo[k][15:0];
    end
  end

  // dividends captured on accept, scaled features in Q2.14 registered in the cycle after
  always_ff @(posedge clk_i) begin
    if (classify_start) begin
      n0_q <= 27'(dvd[0] >> PRE0);
      n1_q <= 26'(dvd[1] >> PRE1);
      n2_q <= 21'(dvd[2]);
    end
    if (state_q == ST_DIV) begin
      for (int k = 0; k < 3; k++) begin
        feat_q[k] <= feat_d[k];
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    unit_d    = unit_q;
    elem_d    = elem_q;
    unique case (state_q)
      ST_IDLE: begin
        if (classify_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        state_d = ST_HID;
        unit_d  = '0;
        elem_d  = SEL_BIAS;
      end
      ST_HID: begin
        elem_d = elem_q + 2'd1;
        if (elem_q == SEL_X2) begin
          if (unit_q == LAST_UNIT) begin
            state_d = ST_DRAIN;
            unit_d  = '0;
          end else begin
            unit_d = unit_q + UW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && !out_valid_q) begin
          state_d = ST_OUT;
          unit_d  = '0;
          elem_d  = SEL_BIAS;
        end
      end
      ST_OUT: begin
        if (elem_q == SEL_BIAS) begin
          elem_d = SEL_X0;
        end else if (unit_q == LAST_UNIT) begin
          state_d = ST_FIN;
        end else begin
          unit_d = unit_q + UW'(1);
        end
      end
      ST_FIN: begin
        if (s4_q.valid && s4_q.layer) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      unit_q    <= '0;
      elem_q    <= SEL_BIAS;
    end else begin
      state_q   <= state_d;
      unit_q    <= unit_d;
      elem_q    <= elem_d;
    end
  end

  // read address and tag for the current element
  always_comb begin
    unique case (elem_q)
      SEL_BIAS: iss_base = HID_BIAS_BASE;
      SEL_X0:   iss_base = '0;
      SEL_X1:   iss_base = HID_W1_BASE;
      SEL_X2:   iss_base = HID_W2_BASE;
      default:  iss_base = '0;
    endcase
    iss.valid = (state_q == ST_HID) || (state_q == ST_OUT);
    iss.first = (elem_q == SEL_BIAS);
    iss.unit  = unit_q;
    if (state_q == ST_OUT) begin
      iss.layer = 1'b1;
      iss.last  = (elem_q != SEL_BIAS) && (unit_q == LAST_UNIT);
      iss.sel   = (elem_q == SEL_BIAS) ? SEL_BIAS : SEL_X0;
      iss_addr  = (elem_q == SEL_BIAS) ? OUT_BIAS_ADDR : (OUT_W_BASE + AW'(unit_q));
    end else begin
      iss.layer = 1'b0;
      iss.last  = (elem_q == SEL_X2);
      iss.sel   = elem_q;
      iss_addr  = iss_base + AW'(unit_q);
    end
  end

  // weight store: load writes, sequencer reads
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      wmem[wr_addr] <= weight_value_i;
    end
    if (iss.valid) begin
      w_rd_q <= wmem[iss_addr];
    end
  end

  // hidden activation store: written by the sigmoid stage, read in the output layer
  always_ff @(posedge clk_i) begin
    if (s4_q.valid && !s4_q.layer) begin
      hmem[s4_q.unit] <= sig_y;
    end
    if (iss.valid) begin
      h_rd_q <= hmem[iss.unit];
    end
  end

  // multiplier operand select
  always_comb begin
    if (s1_q.layer) begin
      opnd = s1_q.first ? ONE_Q16 : {1'b0, h_rd_q};
    end else begin
      unique case (s1_q.sel)
        SEL_BIAS: opnd = ONE_Q14;
        SEL_X0:   opnd = {1'b0, feat_q[0]};
        SEL_X1:   opnd = {1'b0, feat_q[1]};
        SEL_X2:   opnd = {1'b0, feat_q[2]};
        default:  opnd = ONE_Q14;
      endcase
    end
  end

  assign prod_d = 34'(signed'({1'b0, opnd})) * 34'(w_rd_q);

  // sum magnitude rounded to Q.16 and clamped at the top breakpoint
  always_comb begin
    acc_u   = acc_q;
    acc_neg = acc_q[ACC_W-1];
    if (s3_q.layer) begin
      mag    = (acc_neg ? ~acc_u : acc_u)
             + ACC_W'(acc_neg ? ((1 << (OUT_SHIFT - 1)) + 1) : (1 << (OUT_SHIFT - 1)));
      mag_sh = mag >> OUT_SHIFT;
    end else begin
      mag    = (acc_neg ? ~acc_u : acc_u)
             + ACC_W'(acc_neg ? ((1 << (HID_SHIFT - 1)) + 1) : (1 << (HID_SHIFT - 1)));
      mag_sh = mag >> HID_SHIFT;
    end
    a_d = (mag_sh >= ACC_W'(SIG_SAT)) ? SIG_SAT : mag_sh[18:0];
  end

  assign sig_y = plan_sig(a_q, neg_q);

  // only the last element of a neuron moves on to rounding
  always_comb begin
    s3_d       = s2_q;
    s3_d.valid = s2_q.valid && s2_q.last;
  end

  // datapath tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else begin
      s1_q <= iss;
      s2_q <= s1_q;
      s3_q <= s3_d;
      s4_q <= s3_q;
    end
  end

  // product, accumulator and sigmoid registers
  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      prod_q <= prod_d;
    end
    if (s2_q.valid) begin
      acc_q <= s2_q.first ? ACC_W'(prod_q) : (acc_q + ACC_W'(prod_q));
    end
    if (s3_q.valid) begin
      a_q   <= a_d;
      neg_q <= acc_neg;
    end
  end

  // output transaction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s4_q.valid && s4_q.layer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_q.valid && s4_q.layer) begin
      score_q <= sig_y;
      class_q <= (sig_y >= SCORE_HALF);
    end
  end

  assign out_valid_o = out_valid_q;
  assign class_out_o = class_q;
  assign score_o     = score_q;

`ifndef SYNTHESIS
  // hidden activations are never written while the output layer reads them
  a_hmem_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_q.valid && !s4_q.layer) |-> (state_q != ST_OUT))
    else $error("hidden activation write during output layer");

  // a new transaction is only taken with the datapath drained
  a_ready_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> pipe_empty)
    else $error("input ready with datapath busy");

  // a finished score never overwrites a result still waiting
  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_q.valid && s4_q.layer) |-> !out_valid_q)
    else $error("score written over pending result");

  // the sequencer returns to idle right after the score is captured
  a_fin_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_q.valid && s4_q.layer) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle");
`endif

endmodule

/* dv/tb.sv */
// self-checking testbench for the two layer sigmoid perceptron classifier
`timescale 1ns / 100ps

module tb;
  import mlpsc_pkg::*;

  localparam int unsigned HU            = HIDDEN_UNITS_DEF;
  localparam int unsigned STORE_WORDS   = 5 * HU + 1;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned REPORT_CAP    = 200;
  localparam longint      HALF_Q16      = 32768;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CFG,
    STEP_PAUSE
  } step_kind_e;

  typedef struct packed {
    step_kind_e         kind;
    op_e                op;
    logic [5:0]         index;
    logic signed [15:0] value;
    logic [31:0]        first;
    logic [31:0]        second;
    logic [15:0]        level;
  } stim_step_t;

  typedef struct packed {
    logic        is_positive;
    logic [15:0] score;
  } verdict_t;

  // block ports
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [15:0]        cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               op_i           = 1'b0;
  logic [5:0]         weight_index_i = '0;
  logic signed [15:0] weight_value_i = '0;
  logic [31:0]        first_level_i  = '0;
  logic [31:0]        second_level_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               class_out_o;
  logic [15:0]        score_o;

  // predictor state: copy of the weight store and the third feature register
  logic signed [15:0] weight_copy [STORE_WORDS];
  logic [15:0]        third_level;

  stim_step_t  stim_steps [$];
  verdict_t    predicted_verdicts [$];
  stim_step_t  cur_step = '0;
  int unsigned gap_left;
  int unsigned settle_count;
  int unsigned items_taken;
  int unsigned classify_sent;
  int unsigned results_seen;
  int unsigned ready_hold;
  int unsigned quiet_cycles;
  int unsigned error_count = 0;
  logic        stim_done = 1'b0;

  mlp_sigmoid_binary_classifier_unit #(
    .HIDDEN_UNITS(HU)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .weight_index_i (weight_index_i),
    .weight_value_i (weight_value_i),
    .first_level_i  (first_level_i),
    .second_level_i (second_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .class_out_o    (class_out_o),
    .score_o        (score_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (error_count < REPORT_CAP) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // idle cycles before the next transaction, with runs of back-to-back traffic
  function automatic int unsigned idle_draw(input int unsigned n, input int unsigned stretch);
    if ((n / stretch) % 4 == 3) begin
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // feature in Q2.14, saturated at 2.0
  function automatic longint clip_q2_14(input longint v);
    return (v > 32768) ? 64'sd32768 : v;
  endfunction

  // piecewise linear sigmoid of a signed sum with frac_bits fraction bits
  function automatic logic [15:0] squash_q16(input longint acc, input int unsigned frac_bits);
    longint unsigned mag;
    longint unsigned a;
    longint unsigned y;
    int unsigned     sh;
    sh  = frac_bits - 16;
    mag = (acc < 0) ? -acc : acc;
    a   = (mag + (64'd1 << (sh - 1))) >> sh;
    // knees at 5.0, 2.375 and 1.0 in Q.16
    if (a >= 327680) begin
      y = 65536;
    end else if (a >= 155648) begin
      y = (a >> 5) + 55296;
    end else if (a >= 65536) begin
      y = (a >> 3) + 40960;
    end else begin
      y = (a >> 2) + 32768;
    end
    if (acc < 0) begin
      y = 65536 - y;
    end
    if (y > 65535) begin
      y = 65535;
    end
    return y[15:0];
  endfunction

  // full network evaluation for one sample
  function automatic verdict_t classify_sample(input logic [31:0] first,
                                               input logic [31:0] second);
    longint      feat [3];
    longint      hidden [HU];
    longint      acc;
    int unsigned i;
    int unsigned j;
    verdict_t    v;
    feat[0] = clip_q2_14((longint'(first) + 100000) / 200000);
    feat[1] = clip_q2_14((longint'(second) + 40000) / 80000);
    feat[2] = clip_q2_14((longint'(third_level) * 25 + 14) / 29);
    // hidden layer, sums in Q.26
    for (j = 0; j < HU; j++) begin
      acc = longint'(weight_copy[3 * HU + j]) * 16384;
      for (i = 0; i < 3; i++) begin
        acc += feat[i] * longint'(weight_copy[i * HU + j]);
      end
      hidden[j] = longint'(squash_q16(acc, 26));
    end
    // output neuron, sum in Q.28
    acc = longint'(weight_copy[5 * HU]) * 65536;
    for (j = 0; j < HU; j++) begin
      acc += hidden[j] * longint'(weight_copy[4 * HU + j]);
    end
    v.score       = squash_q16(acc, 28);
    v.is_positive = (longint'(v.score) >= HALF_Q16);
    return v;
  endfunction

  // apply one accepted transaction to the predictor
  task automatic absorb_item(input stim_step_t s);
    if (s.op == OP_LOAD) begin
      if (s.index < STORE_WORDS) begin
        weight_copy[s.index] = s.value;
      end
    end else begin
      predicted_verdicts.insert(predicted_verdicts.size(), classify_sample(s.first, s.second));
      classify_sent++;
    end
  endtask

  // weight word: 0 within +-1.0, 1 full range, 2 the two extremes
  function automatic logic signed [15:0] draw_weight(input int unsigned style);
    case (style)
      0:       return 16'($urandom_range(0, 8191) - 4096);
      1:       return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // concentration: small, mid, rounding and saturation edges, or anything
  function automatic logic [31:0] draw_level();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32'h00FF_FFFF);
      1: return $urandom_range(0, 32'h3FFF_FFFF);
      2: begin
        case ($urandom_range(0, 7))
          0:       return 32'd0;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'd99999;
          3:       return 32'd100000;
          4:       return 32'd39999;
          5:       return 32'd40000;
          6:       return 32'd2621399999;
          default: return 32'd2621400000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic push_load(input logic [5:0] idx, input logic signed [15:0] val);
    stim_step_t s;
    s.kind   = STEP_ITEM;
    s.op     = OP_LOAD;
    s.index  = idx;
    s.value  = val;
    s.first  = $urandom;
    s.second = $urandom;
    s.level  = '0;
    stim_steps.insert(stim_steps.size(), s);
  endtask

  task automatic push_classify(input logic [31:0] first, input logic [31:0] second);
    stim_step_t s;
    s.kind   = STEP_ITEM;
    s.op     = OP_CLASSIFY;
    s.index  = 6'($urandom_range(0, 63));
    s.value  = 16'($urandom);
    s.first  = first;
    s.second = second;
    s.level  = '0;
    stim_steps.insert(stim_steps.size(), s);
  endtask

  // sender waits until every result is back, then lets the block settle
  task automatic push_pause();
    stim_step_t s;
    s      = '0;
    s.kind = STEP_PAUSE;
    stim_steps.insert(stim_steps.size(), s);
  endtask

  // stimulus plan and end of test
  initial begin : stimulus
    logic [15:0] levels [6];
    stim_step_t  c;
    int unsigned idx;
    int unsigned p;
    int unsigned made;
    int unsigned n;
    int unsigned m;
    int unsigned style;
    int unsigned pick;
    levels[0] = 16'd0;
    levels[1] = 16'hFFFF;
    levels[2] = 16'd38010;
    levels[3] = 16'd38011;
    levels[4] = 16'($urandom);
    levels[5] = 16'($urandom);

    // fill the whole store before any classify, word extremes first
    for (idx = 0; idx < STORE_WORDS; idx++) begin
      push_load(6'(idx), (idx == 0) ? 16'sh7FFF : (idx == 1) ? 16'sh8000 : draw_weight(0));
    end
    // loads past the store must leave it untouched
    push_load(6'(STORE_WORDS), 16'sh7FFF);
    push_load(6'd63, 16'sh8000);
    // feature extremes, rounding points and the saturation edge of the second input
    push_classify(32'd0, 32'd0);
    push_classify(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_classify(32'd99999, 32'd39999);
    push_classify(32'd100000, 32'd40000);
    push_classify(32'hFFFF_FFFF, 32'd2621399999);
    push_classify(32'd0, 32'd2621400000);
    // output bias at both extremes
    push_load(6'(5 * HU), 16'sh7FFF);
    push_classify(draw_level(), draw_level());
    push_load(6'(5 * HU), 16'sh8000);
    push_classify(draw_level(), draw_level());

    // random phases, one third feature setting each
    for (p = 0; p < 6; p++) begin
      push_pause();
      c       = '0;
      c.kind  = STEP_CFG;
      c.level = levels[p];
      stim_steps.insert(stim_steps.size(), c);
      made = 0;
      while (made < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          // rewrite a few words, then classify a handful of samples
          n     = $urandom_range(0, 6);
          m     = $urandom_range(1, 4);
          style = $urandom_range(0, 2);
          repeat (n) push_load(6'($urandom_range(0, STORE_WORDS - 1)), draw_weight(style));
          repeat (m) push_classify(draw_level(), draw_level());
          made += n + m;
        end else if (pick < 16) begin
          // complete reload in one style
          style = $urandom_range(0, 2);
          for (idx = 0; idx < STORE_WORDS; idx++) begin
            push_load(6'(idx), draw_weight(style));
          end
          push_classify(draw_level(), draw_level());
          made += STORE_WORDS + 1;
        end else if (pick < 18) begin
          // stray loads outside the store
          repeat ($urandom_range(1, 4)) begin
            push_load(6'($urandom_range(STORE_WORDS, 63)), 16'($urandom));
          end
          push_classify(draw_level(), draw_level());
          made += 1;
        end else begin
          // drain fully, then a burst of samples
          push_pause();
          m = $urandom_range(2, 6);
          repeat (m) push_classify(draw_level(), draw_level());
          made += m;
        end
      end
    end
    push_pause();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_done);
    if (predicted_verdicts.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", predicted_verdicts.size()));
    end
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // driver: input transactions, config writes and pauses from the plan
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic offer;
    logic write_cfg;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      cfg_we_i      <= 1'b0;
      gap_left      = 0;
      settle_count  = 0;
      items_taken   = 0;
      classify_sent = 0;
      third_level   = THIRD_RESET;
    end else begin
      offer     = in_valid_i;
      write_cfg = 1'b0;
      if (in_valid_i && in_ready_o) begin
        absorb_item(cur_step);
        items_taken++;
        offer    = 1'b0;
        gap_left = idle_draw(items_taken, 80);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_steps.size() == 0) begin
          stim_done <= 1'b1;
        end else begin
          case (stim_steps[0].kind)
            STEP_ITEM: begin
              cur_step = stim_steps.pop_front();
              offer    = 1'b1;
            end
            STEP_CFG: begin
              cur_step    = stim_steps.pop_front();
              third_level = cur_step.level;
              write_cfg   = 1'b1;
            end
            STEP_PAUSE: begin
              if (classify_sent != results_seen) begin
                settle_count = 0;
              end else if (settle_count < SETTLE_CYCLES) begin
                settle_count++;
              end else begin
                void'(stim_steps.pop_front());
                settle_count = 0;
              end
            end
            default: begin
              void'(stim_steps.pop_front());
            end
          endcase
        end
      end
      in_valid_i     <= offer;
      cfg_we_i       <= write_cfg;
      cfg_wdata_i    <= cur_step.level;
      op_i           <= cur_step.op;
      weight_index_i <= cur_step.index;
      weight_value_i <= cur_step.value;
      first_level_i  <= cur_step.first;
      second_level_i <= cur_step.second;
    end
  end

  // monitor: result transactions against the oldest prediction, random backpressure
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    verdict_t want;
    logic     take;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      results_seen <= 0;
      ready_hold   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_verdicts.size() == 0) begin
          flag_error($sformatf("result with nothing pending: class %0b score %0d",
                               class_out_o, score_o));
        end else begin
          want = predicted_verdicts.pop_front();
          if (class_out_o !== want.is_positive) begin
            flag_error($sformatf("result %0d class %0b, want %0b",
                                 results_seen, class_out_o, want.is_positive));
          end
          if (score_o !== want.score) begin
            flag_error($sformatf("result %0d score %0d, want %0d",
                                 results_seen, score_o, want.score));
          end
        end
        results_seen <= results_seen + 1;
        ready_hold   = idle_draw(results_seen, 50);
        // a few long holds so the block backs up into its input
        if (results_seen == 39 || results_seen == 249 || results_seen == 499) begin
          ready_hold = LONG_HOLD;
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_ready_i <= take;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR @%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* mlp_sigmoid_binary_classifier_unit.f */
rtl/mlpsc_pkg.sv
rtl/mlp_sigmoid_binary_classifier_unit.sv
dv/tb.sv
